// ===== hw/rtl/trh_pkg.sv =====
// Shared types, codes and sizes for the TFTP receive handler.
`default_nettype none

package trh_pkg;

	// TFTP opcodes seen by the handler
	localparam logic [15:0] OP_DATA  = 16'd3;
	localparam logic [15:0] OP_ACK   = 16'd4;
	localparam logic [15:0] OP_ERROR = 16'd5;

	localparam logic [15:0] FIRST_DATA_BLOCK = 16'd1;
	localparam logic [15:0] FIRST_ACK_BLOCK  = 16'd0;
	localparam logic [15:0] WELL_KNOWN_PORT_RST = 16'd69;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WRITE_MODE      = 1'b0,
		CFG_WELL_KNOWN_PORT = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		KIND_START  = 1'b0,
		KIND_PACKET = 1'b1
	} item_kind_t;

	typedef enum logic [1:0] {
		ACT_DROP    = 2'd0,
		ACT_ACCEPT  = 2'd1,
		ACT_REACK   = 2'd2,
		ACT_TID_ERR = 2'd3
	} action_t;

	// command classes handed from the front to the back
	typedef enum logic [2:0] {
		CMD_START,
		CMD_DATA,
		CMD_ACK,
		CMD_ERROR,
		CMD_IGNORE
	} cmd_kind_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] opcode;
		logic [15:0] block_number;
		logic [15:0] source_port;
		logic [9:0]  payload_length;
	} in_item_t;

	typedef struct packed {
		action_t     action;
		logic [15:0] ack_block;
		logic [15:0] error_port;
		logic [15:0] next_expected;
		logic        connection_open;
		logic        error_seen;
		logic [31:0] bytes_received;
	} result_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [15:0] block;
		logic [15:0] port;
		logic [9:0]  length;
	} cmd_t;

	// queue sizes (powers of two: pointers wrap naturally)
	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	localparam int RES_DEPTH = 2;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

endpackage

`default_nettype wire

// ===== hw/rtl/trh_front.sv =====
// Front end: classifies incoming items and queues them as commands.
`default_nettype none

module trh_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  trh_pkg::in_item_t item,
	output logic              full,
	output logic              cmd_valid,
	input  wire               cmd_ready,
	output trh_pkg::cmd_t     cmd
);

	trh_pkg::cmd_t                    cmd_mem [trh_pkg::CMD_DEPTH];
	logic [trh_pkg::CMD_PTR_W-1:0]    wr_ptr_q;
	logic [trh_pkg::CMD_PTR_W-1:0]    rd_ptr_q;
	logic [trh_pkg::CMD_CNT_W-1:0]    count_q;
	trh_pkg::cmd_t                    new_cmd;
	logic                             do_push;
	logic                             do_pop;

	always_comb begin
		new_cmd.block  = item.block_number;
		new_cmd.port   = item.source_port;
		new_cmd.length = item.payload_length;
		if (item.kind == trh_pkg::KIND_START) begin
			new_cmd.kind = trh_pkg::CMD_START;
		end else begin
			unique case (item.opcode)
				trh_pkg::OP_DATA:  new_cmd.kind = trh_pkg::CMD_DATA;
				trh_pkg::OP_ACK:   new_cmd.kind = trh_pkg::CMD_ACK;
				trh_pkg::OP_ERROR: new_cmd.kind = trh_pkg::CMD_ERROR;
				default:           new_cmd.kind = trh_pkg::CMD_IGNORE;
			endcase
		end
	end

	assign full      = (count_q == trh_pkg::CMD_CNT_W'(trh_pkg::CMD_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = cmd_mem[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			cmd_mem[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/trh_back.sv =====
// Back end: session state, per-command checks and the result queue.
`default_nettype none

module trh_back (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_wr_en,
	input  wire [trh_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [trh_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire                                cmd_valid,
	output logic                               cmd_ready,
	input  trh_pkg::cmd_t                      cmd,
	output logic                               empty,
	input  wire                                pop,
	output trh_pkg::result_t                   result
);

	logic        write_mode_q;
	logic [15:0] well_known_port_q;

	logic [15:0] expected_q;
	logic [15:0] server_port_q;
	logic        open_q;
	logic        error_q;
	logic [31:0] byte_count_q;

	logic [15:0] expected_d;
	logic [15:0] server_port_d;
	logic        open_d;
	logic        error_d;
	logic [31:0] byte_count_d;
	trh_pkg::result_t res_d;

	logic        in_order;
	logic        first_blk;
	logic [15:0] first_value;

	trh_pkg::result_t              res_mem [trh_pkg::RES_DEPTH];
	logic [trh_pkg::RES_PTR_W-1:0] wr_ptr_q;
	logic [trh_pkg::RES_PTR_W-1:0] rd_ptr_q;
	logic [trh_pkg::RES_CNT_W-1:0] count_q;
	logic                          step;
	logic                          do_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_mode_q      <= 1'b0;
			well_known_port_q <= trh_pkg::WELL_KNOWN_PORT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				trh_pkg::CFG_WRITE_MODE:      write_mode_q      <= cfg_data[0];
				trh_pkg::CFG_WELL_KNOWN_PORT: well_known_port_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cmd_ready = (count_q != trh_pkg::RES_CNT_W'(trh_pkg::RES_DEPTH));
	assign step      = cmd_valid && cmd_ready;

	assign in_order    = (cmd.block == expected_q);
	assign first_value = (cmd.kind == trh_pkg::CMD_DATA) ? trh_pkg::FIRST_DATA_BLOCK
	                                                     : trh_pkg::FIRST_ACK_BLOCK;
	assign first_blk   = (cmd.block == first_value);

	always_comb begin
		expected_d    = expected_q;
		server_port_d = server_port_q;
		open_d        = open_q;
		error_d       = error_q;
		byte_count_d  = byte_count_q;
		res_d.action     = trh_pkg::ACT_DROP;
		res_d.ack_block  = '0;
		res_d.error_port = '0;
		case (cmd.kind)
			trh_pkg::CMD_START: begin
				expected_d    = write_mode_q ? trh_pkg::FIRST_ACK_BLOCK
				                             : trh_pkg::FIRST_DATA_BLOCK;
				server_port_d = well_known_port_q;
				open_d        = 1'b0;
				error_d       = 1'b0;
				byte_count_d  = '0;
			end
			trh_pkg::CMD_DATA, trh_pkg::CMD_ACK: begin
				if (in_order) begin
					if (!first_blk && server_port_q != cmd.port) begin
						// reply from a stranger: refuse, leave the session alone
						res_d.action     = trh_pkg::ACT_TID_ERR;
						res_d.error_port = cmd.port;
					end else begin
						res_d.action = trh_pkg::ACT_ACCEPT;
						expected_d   = expected_q + 16'd1;
						if (first_blk) begin
							server_port_d = cmd.port;
							open_d        = 1'b1;
						end
						if (cmd.kind == trh_pkg::CMD_DATA) begin
							byte_count_d = byte_count_q + {22'd0, cmd.length};
						end
					end
				end else if (cmd.kind == trh_pkg::CMD_DATA && cmd.block < expected_q) begin
					res_d.action    = trh_pkg::ACT_REACK;
					res_d.ack_block = cmd.block;
				end
			end
			trh_pkg::CMD_ERROR: begin
				error_d = 1'b1;
			end
			default: ;
		endcase
		res_d.next_expected   = expected_d;
		res_d.connection_open = open_d;
		res_d.error_seen      = error_d;
		res_d.bytes_received  = byte_count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q    <= trh_pkg::FIRST_DATA_BLOCK;
			server_port_q <= trh_pkg::WELL_KNOWN_PORT_RST;
			open_q        <= 1'b0;
			error_q       <= 1'b0;
			byte_count_q  <= '0;
		end else if (step) begin
			expected_q    <= expected_d;
			server_port_q <= server_port_d;
			open_q        <= open_d;
			error_q       <= error_d;
			byte_count_q  <= byte_count_d;
		end
	end

	// result queue
	assign empty  = (count_q == '0);
	assign result = res_mem[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (step) begin
			res_mem[wr_ptr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (step) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (step && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !step) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tftp_receive_handler.sv =====
// TFTP client receive handler: top level joining the front and back ends.
// One result per item, one item per cycle sustained while results are popped.
// An item pushed with nothing queued ahead of it is written into the front's
// command queue, checked against the session state as the back takes it and
// written into the result queue, where it shows (empty low). The front holds
// up to 4 classified commands and the back up to 2 finished results, so full
// rises only when results are not popped. A configuration write lands at the
// edge where cfg_wr_en is high; write only while no item is in flight.
`default_nettype none

module tftp_receive_handler (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_wr_en,
	input  wire [trh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [trh_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire                           push,
	input  trh_pkg::in_item_t             item,
	output logic                          full,
	output logic                          empty,
	input  wire                           pop,
	output trh_pkg::result_t              result
);

	logic          cmd_valid;
	logic          cmd_ready;
	trh_pkg::cmd_t cmd;

	trh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	trh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/trh_checker.sv =====
// Port-level checks on the TFTP receive handler results, bound to the top.
`default_nettype none

module trh_checker (
	input wire              clk,
	input wire              arst_n,
	input wire              empty,
	input wire              pop,
	input trh_pkg::result_t result
);

	// a waiting result holds until it is transferred
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while stalled");

	a_reack_older: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.action == trh_pkg::ACT_REACK)
			|-> (result.ack_block < result.next_expected))
		else $error("re-ack of a block that is not older than expected");

	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.action != trh_pkg::ACT_REACK) |-> (result.ack_block == 16'd0))
		else $error("ack_block set without re-ack");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.action != trh_pkg::ACT_TID_ERR) |-> (result.error_port == 16'd0))
		else $error("error_port set without transfer-ID error");

endmodule

bind tftp_receive_handler trh_checker u_trh_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

`default_nettype wire
